@@ rtl/core/rvd_pkg.sv @@
// Shared types, widths and constants for the radial vertex displacement core.
package rvd_pkg;

   // Fixed formats of the fields and of the arithmetic
   localparam int COORD_BITS   = 10;
   localparam int FRAC_BITS    = 8;
   localparam int MAX_DIST     = 400;
   localparam int IDX_W        = 14;
   localparam int PTR_W        = 12;
   localparam int CFG_W        = 8;
   localparam int OUT_W        = 20;
   localparam int DIFF_W       = 13;
   localparam int ABS_W        = 12;
   localparam int SQ_W         = 25;
   localparam int RAD_W        = 42;
   localparam int ROOT_W       = 21;
   localparam int ROOT_STAGES  = 21;
   localparam int DIST_W       = 9;
   localparam int GAIN_W       = 10;
   localparam int NUM_W        = 19;
   localparam int NMAG_W       = 18;
   // ceil(2^26 / 400): exact truncated quotient for every magnitude up to 51200
   localparam int RECIP        = 167773;
   localparam int RECIP_SHIFT  = 26;
   localparam int RPROD_W      = 36;
   localparam int DMAG_W       = 9;
   localparam int PROD_W       = 21;
   localparam int DIVN_W       = 37;
   localparam int QUO_W        = 18;
   localparam int REM_W        = 22;

   // Pipeline depth of each section
   localparam int FRONT_STAGES = 3;
   localparam int DISP_STAGES  = 4;
   localparam int DIV_STAGES   = QUO_W;
   localparam int LATENCY      = FRONT_STAGES + ROOT_STAGES + DISP_STAGES + DIV_STAGES + 1;

   localparam logic signed [CFG_W-1:0] ATTRACT_RESET = 8'sd20;
   localparam logic signed [CFG_W-1:0] REPEL_RESET   = -8'sd20;

   typedef enum logic [0:0] {
      CSR_ATTRACT = 1'b0,
      CSR_REPEL   = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [IDX_W-1:0]             vertex_index;
      logic [COORD_BITS-1:0]        vertex_x;
      logic [COORD_BITS-1:0]        vertex_y;
      logic signed [PTR_W-1:0]      pointer_x;
      logic signed [PTR_W-1:0]      pointer_y;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]             result_index;
      logic signed [OUT_W-1:0]      moved_x_q8;
      logic signed [OUT_W-1:0]      moved_y_q8;
   } rsp_type;

   typedef struct packed {
      logic signed [CFG_W-1:0]      attract;
      logic signed [CFG_W-1:0]      repel;
   } cfg_type;

   // Per-vertex data that rides along the pipeline; axis 0 is x, axis 1 is y
   typedef struct packed {
      logic [IDX_W-1:0]                  index;
      logic [1:0][COORD_BITS-1:0]        coord;
      logic [1:0][ABS_W-1:0]             mag;
      logic [1:0]                        neg;
   } side_type;

   typedef struct packed {
      side_type                 side;
      logic [SQ_W-1:0]          sq;
   } sq_type;

   typedef struct packed {
      side_type                 side;
      logic [ROOT_W-1:0]        root;
   } len_type;

   typedef struct packed {
      side_type                 side;
      logic [ROOT_W-1:0]        root;
      logic [1:0][DIVN_W-1:0]   num;
      logic [1:0]               off_neg;
   } quot_in_type;

   typedef struct packed {
      side_type                 side;
      logic [1:0][QUO_W-1:0]    quo;
      logic [1:0]               off_neg;
   } quot_out_type;

endpackage

@@ rtl/core/rvd_front.sv @@
// Front stages: difference vector, squares and squared length.
module rvd_front import rvd_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   input  req_type in_req,
   output logic   out_valid,
   output sq_type out_sq
);

   logic [FRONT_STAGES-1:0]     valid_ff;
   logic signed [DIFF_W-1:0]    dx_in, dy_in, dx_ff, dy_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [1:0][COORD_BITS-1:0]  coord_ff;
   logic signed [2*DIFF_W-1:0]  sqx_p, sqy_p;
   logic [SQ_W-2:0]             sqx_ff, sqy_ff;
   side_type                    side_in, side_ff;
   sq_type                      out_in;

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   // stage 1: difference vector
   assign dx_in = DIFF_W'(in_req.pointer_x) - DIFF_W'(in_req.vertex_x);
   assign dy_in = DIFF_W'(in_req.pointer_y) - DIFF_W'(in_req.vertex_y);

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      idx_ff   <= in_req.vertex_index;
      coord_ff <= {in_req.vertex_y, in_req.vertex_x};
   end

   // stage 2: squares, magnitudes and signs
   assign sqx_p = dx_ff * dx_ff;
   assign sqy_p = dy_ff * dy_ff;

   always_comb begin
      side_in.index  = idx_ff;
      side_in.coord  = coord_ff;
      side_in.mag[0] = dx_ff[DIFF_W-1] ? ABS_W'(-dx_ff) : ABS_W'(dx_ff);
      side_in.mag[1] = dy_ff[DIFF_W-1] ? ABS_W'(-dy_ff) : ABS_W'(dy_ff);
      side_in.neg    = {dy_ff[DIFF_W-1], dx_ff[DIFF_W-1]};
   end

   always_ff @(posedge clock) begin
      sqx_ff  <= sqx_p[SQ_W-2:0];
      sqy_ff  <= sqy_p[SQ_W-2:0];
      side_ff <= side_in;
   end

   // stage 3: squared length
   assign out_in.side = side_ff;
   assign out_in.sq   = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);

   always_ff @(posedge clock) begin
      out_sq <= out_in;
   end

   assign out_valid = valid_ff[FRONT_STAGES-1];

endmodule

@@ rtl/core/rvd_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module rvd_sqrt import rvd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  sq_type  in_sq,
   output logic    out_valid,
   output len_type out_len
);

   logic [ROOT_STAGES-1:0]  valid_ff;
   logic [RAD_W-1:0]        rem_ff  [ROOT_STAGES-1];
   logic [RAD_W-1:0]        root_ff [ROOT_STAGES];
   side_type                side_ff [ROOT_STAGES];

   genvar i;
   for (i = 0; i < ROOT_STAGES; i++) begin : g_stage
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ROOT_STAGES - 1 - i));
      logic [RAD_W-1:0] rem_src, root_src, trial, root_in;
      logic             valid_src, take;
      side_type         side_src;

      if (i == 0) begin : g_first
         assign rem_src   = RAD_W'(in_sq.sq) << (2 * FRAC_BITS);
         assign root_src  = '0;
         assign valid_src = in_valid;
         assign side_src  = in_sq.side;
      end else begin : g_next
         assign rem_src   = rem_ff[i-1];
         assign root_src  = root_ff[i-1];
         assign valid_src = valid_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      // try the next root bit
      assign trial   = root_src + BIT;
      assign take    = rem_src >= trial;
      assign root_in = take ? ((root_src >> 1) + BIT) : (root_src >> 1);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         root_ff[i] <= root_in;
         side_ff[i] <= side_src;
      end

      // the remainder is not needed after the last bit
      if (i < ROOT_STAGES - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[i] <= take ? (rem_src - trial) : rem_src;
         end
      end
   end

   assign out_valid    = valid_ff[ROOT_STAGES-1];
   assign out_len.side = side_ff[ROOT_STAGES-1];
   assign out_len.root = root_ff[ROOT_STAGES-1][ROOT_W-1:0];

endmodule

@@ rtl/core/rvd_disp.sv @@
// Displacement from distance, and the per-axis offset numerators.
module rvd_disp import rvd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   input  len_type     in_len,
   output logic        out_valid,
   output quot_in_type out_num
);

   logic [DISP_STAGES-1:0]      valid_ff;
   logic [ROOT_W-FRAC_BITS-1:0] whole;
   logic [DIST_W-1:0]           dist_clamp;
   logic signed [GAIN_W-1:0]    gain;
   logic signed [NUM_W-1:0]     num_in, num_ff;
   logic [NMAG_W-1:0]           mag_in;
   logic [RPROD_W-1:0]          rp_in, rp_ff;
   logic                        dneg_ff;
   logic [DMAG_W-1:0]           dmag_ff;
   logic [1:0]                  offneg_ff;
   len_type                     s1_ff, s2_ff, s3_ff;
   quot_in_type                 out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DISP_STAGES-2:0], in_valid};
      end
   end

   // stage 1: clamp distance, form attract*400 + d*(-repel - attract)
   assign whole = in_len.root[ROOT_W-1:FRAC_BITS];
   assign dist_clamp = (whole > (ROOT_W-FRAC_BITS)'(MAX_DIST)) ? DIST_W'(MAX_DIST)
                                                               : whole[DIST_W-1:0];
   assign gain  = -GAIN_W'(cfg.repel) - GAIN_W'(cfg.attract);
   assign num_in = NUM_W'(cfg.attract) * NUM_W'(MAX_DIST)
                 + NUM_W'(signed'({1'b0, dist_clamp})) * NUM_W'(gain);

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      s1_ff  <= in_len;
   end

   // stage 2: magnitude times the reciprocal of 400
   assign mag_in = num_ff[NUM_W-1] ? NMAG_W'(-num_ff) : NMAG_W'(num_ff);
   assign rp_in  = RPROD_W'(mag_in) * RPROD_W'(RECIP);

   always_ff @(posedge clock) begin
      rp_ff   <= rp_in;
      dneg_ff <= num_ff[NUM_W-1];
      s2_ff   <= s1_ff;
   end

   // stage 3: truncated displacement magnitude and the offset signs
   always_ff @(posedge clock) begin
      dmag_ff   <= rp_ff[RECIP_SHIFT +: DMAG_W];
      offneg_ff <= s2_ff.side.neg ^ {2{dneg_ff}};
      s3_ff     <= s2_ff;
   end

   // stage 4: scaled numerators disp * delta << 2*FRAC_BITS
   always_comb begin
      out_in.side    = s3_ff.side;
      out_in.root    = s3_ff.root;
      out_in.off_neg = offneg_ff;
      for (int a = 0; a < 2; a++) begin
         out_in.num[a] = DIVN_W'(PROD_W'(dmag_ff) * PROD_W'(s3_ff.side.mag[a]))
                         << (2 * FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      out_num <= out_in;
   end

   assign out_valid = valid_ff[DISP_STAGES-1];

endmodule

@@ rtl/core/rvd_div.sv @@
// Pipelined restoring divider for both axes, one quotient bit per stage.
module rvd_div import rvd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  quot_in_type  in_num,
   output logic         out_valid,
   output quot_out_type out_quo
);

   logic [DIV_STAGES-1:0]      valid_ff;
   logic [ROOT_W-1:0]          dvs_in;
   logic [ROOT_W-1:0]          dvs_ff  [DIV_STAGES-1];
   logic [1:0][DIVN_W-1:0]     num_ff  [DIV_STAGES-1];
   logic [1:0][REM_W-1:0]      rem_ff  [DIV_STAGES-1];
   logic [1:0][QUO_W-1:0]      quo_ff  [DIV_STAGES];
   side_type                   side_ff [DIV_STAGES];
   logic [1:0]                 neg_ff  [DIV_STAGES];

   // a zero length only comes with a zero numerator; divide it by one
   assign dvs_in = (in_num.root == '0) ? ROOT_W'(1) : in_num.root;

   genvar j, a;
   for (j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int BPOS = QUO_W - 1 - j;
      logic [ROOT_W-1:0]       dvs_src;
      logic [1:0][DIVN_W-1:0]  num_src;
      logic [1:0][REM_W-1:0]   rem_src, rem_in;
      logic [1:0][QUO_W-1:0]   quo_src, quo_in;
      logic                    valid_src;
      side_type                side_src;
      logic [1:0]              neg_src;

      if (j == 0) begin : g_first
         assign dvs_src   = dvs_in;
         assign num_src   = in_num.num;
         assign quo_src   = '0;
         assign valid_src = in_valid;
         assign side_src  = in_num.side;
         assign neg_src   = in_num.off_neg;
         for (a = 0; a < 2; a++) begin : g_init
            assign rem_src[a] = REM_W'(in_num.num[a][DIVN_W-1:QUO_W]);
         end
      end else begin : g_next
         assign dvs_src   = dvs_ff[j-1];
         assign num_src   = num_ff[j-1];
         assign rem_src   = rem_ff[j-1];
         assign quo_src   = quo_ff[j-1];
         assign valid_src = valid_ff[j-1];
         assign side_src  = side_ff[j-1];
         assign neg_src   = neg_ff[j-1];
      end

      // shift in the next numerator bit, subtract when it fits
      for (a = 0; a < 2; a++) begin : g_axis
         logic [REM_W-1:0] shifted;
         logic             take;
         assign shifted    = {rem_src[a][REM_W-2:0], num_src[a][BPOS]};
         assign take       = shifted >= REM_W'(dvs_src);
         assign rem_in[a]  = take ? (shifted - REM_W'(dvs_src)) : shifted;
         assign quo_in[a]  = quo_src[a] | (QUO_W'(take) << BPOS);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         quo_ff[j]  <= quo_in;
         side_ff[j] <= side_src;
         neg_ff[j]  <= neg_src;
      end

      if (j < DIV_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            dvs_ff[j] <= dvs_src;
            num_ff[j] <= num_src;
            rem_ff[j] <= rem_in;
         end
      end
   end

   assign out_valid       = valid_ff[DIV_STAGES-1];
   assign out_quo.side    = side_ff[DIV_STAGES-1];
   assign out_quo.quo     = quo_ff[DIV_STAGES-1];
   assign out_quo.off_neg = neg_ff[DIV_STAGES-1];

endmodule

@@ rtl/core/radial_vertex_displacement_core.sv @@
// Top level of the radial vertex displacement core.
//
// Pushes one mesh vertex along the line to a pointer position. A transaction
// is taken at each rising edge with start high and busy low; busy stays low,
// so a new vertex may enter in every cycle. The result (index and moved
// coordinates in Q8) appears on rsp_data with rsp_valid high for exactly one
// cycle, in input order. The pipeline holds the 21-stage square root (one
// root bit per stage) and the 18-stage divider (one quotient bit per stage),
// plus 3 front stages, 4 displacement stages and the output register.
// The receiver cannot stall: results leave whether taken or not.
// Reset (synchronous, active high) empties the pipeline and loads the
// strengths with attract 20 and repel -20. Strengths are written through
// csr_we / csr_idx / csr_wdata at any edge; write them only while no
// transaction is in flight. A vertex exactly on the pointer comes back
// unchanged.
module radial_vertex_displacement_core import rvd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [0:0]       csr_idx,
   input  logic [CFG_W-1:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          front_valid, sqrt_valid, disp_valid, div_valid;
   sq_type        front_sq;
   len_type       sqrt_len;
   quot_in_type   disp_num;
   quot_out_type  div_quo;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   assign busy = 1'b0;

   // strength registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_ATTRACT: cfg_in.attract = signed'(csr_wdata);
            CSR_REPEL:   cfg_in.repel   = signed'(csr_wdata);
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attract <= ATTRACT_RESET;
         cfg_ff.repel   <= REPEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rvd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_data),
      .out_valid (front_valid),
      .out_sq    (front_sq)
   );

   rvd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_sq     (front_sq),
      .out_valid (sqrt_valid),
      .out_len   (sqrt_len)
   );

   rvd_disp u_disp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (sqrt_valid),
      .in_len    (sqrt_len),
      .out_valid (disp_valid),
      .out_num   (disp_num)
   );

   rvd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (disp_valid),
      .in_num    (disp_num),
      .out_valid (div_valid),
      .out_quo   (div_quo)
   );

   // apply the signed offsets to the vertex in Q8
   always_comb begin
      logic [1:0][OUT_W-1:0] base, off, moved;
      for (int a = 0; a < 2; a++) begin
         base[a]  = OUT_W'(div_quo.side.coord[a]) << FRAC_BITS;
         off[a]   = OUT_W'(div_quo.quo[a]);
         moved[a] = div_quo.off_neg[a] ? (base[a] - off[a]) : (base[a] + off[a]);
      end
      rsp_in.result_index = div_quo.side.index;
      rsp_in.moved_x_q8   = signed'(moved[0]);
      rsp_in.moved_y_q8   = signed'(moved[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/rvd_checker.sv @@
// Port-level checks of the radial vertex displacement core, with its bind.
module rvd_checker import rvd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every transaction leaves after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("transaction did not produce a result on time");

   // no result without a transaction
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a transaction");

   // index travels with its vertex
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.result_index == $past(req_data.vertex_index, LATENCY))
      else $error("result index does not match its transaction");

   // pointer on the vertex leaves the vertex unchanged
   a_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid
      && $past(req_data.pointer_x == {2'b00, req_data.vertex_x}, LATENCY)
      && $past(req_data.pointer_y == {2'b00, req_data.vertex_y}, LATENCY)
      |-> rsp_data.moved_x_q8 == {(OUT_W-COORD_BITS-FRAC_BITS)'(0),
                                  $past(req_data.vertex_x, LATENCY), FRAC_BITS'(0)}
       && rsp_data.moved_y_q8 == {(OUT_W-COORD_BITS-FRAC_BITS)'(0),
                                  $past(req_data.vertex_y, LATENCY), FRAC_BITS'(0)})
      else $error("vertex on the pointer was moved");

endmodule

bind radial_vertex_displacement_core rvd_checker u_rvd_checker (.*);
